// File: hdl/pcp_pkg.sv
`default_nettype none
package pcp_pkg;

   // request opcodes
   localparam logic [1:0] OP_RETIRE = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   // result kinds
   localparam logic KIND_LOOP = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // control register indexes
   localparam logic [1:0] CSR_START_PC   = 2'd0;
   localparam logic [1:0] CSR_LOOP_TRACK = 2'd1;
   localparam logic [1:0] CSR_LOOP_LIMIT = 2'd2;

   localparam logic [15:0] PC_NONE = 16'hFFFF;
   localparam logic [63:0] SAT64   = 64'hFFFF_FFFF_FFFF_FFFF;

   // command passed from front to back
   typedef struct packed {
      logic        rd;          // entry read
      logic        upd;         // table update for a retire
      logic        emit;        // loop record goes out
      logic [15:0] addr;        // entry pc (previous pc for update)
      logic [15:0] cyc;
      logic [15:0] loop_first;
      logic [15:0] loop_len;
      logic [31:0] loop_iters;
   } pcp_cmd_type;

   // status from back to front
   typedef struct packed {
      logic clear_done;
   } pcp_status_type;

   // one table entry
   typedef struct packed {
      logic [63:0] count;
      logic [63:0] cycles;
      logic [15:0] min_cyc;
      logic [15:0] max_cyc;
   } pcp_entry_type;

   // result beat payload
   typedef struct packed {
      logic        kind;
      logic [15:0] addr;
      logic [15:0] loop_len;
      logic [31:0] loop_iters;
      logic [63:0] exec_count;
      logic [63:0] cycle_sum;
      logic [15:0] cycle_spread;
      logic [63:0] total_count;
      logic [63:0] total_cycles;
   } pcp_rsp_type;

endpackage
`default_nettype wire

// File: hdl/pcp_ifs.sv
`default_nettype none
interface pcp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] pc;
   logic [15:0] instr_cycles;
   modport source (output valid, op, pc, instr_cycles, input ready);
   modport sink (input valid, op, pc, instr_cycles, output ready);
endinterface

interface pcp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] addr;
   logic [15:0] loop_len;
   logic [31:0] loop_iters;
   logic [63:0] exec_count;
   logic [63:0] cycle_sum;
   logic [15:0] cycle_spread;
   logic [63:0] total_count;
   logic [63:0] total_cycles;
   modport source (output valid, kind, addr, loop_len, loop_iters, exec_count, cycle_sum,
                   cycle_spread, total_count, total_cycles, input ready);
   modport sink (input valid, kind, addr, loop_len, loop_iters, exec_count, cycle_sum,
                 cycle_spread, total_count, total_cycles, output ready);
endinterface

interface pcp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/pcp_fifo.sv
`default_nettype none
module pcp_fifo
   import pcp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire pcp_cmd_type push_data,
   input  wire logic        pop,
   output pcp_cmd_type      pop_data,
   output logic             full,
   output logic             empty
);
   localparam int DEPTH = 4;

   pcp_cmd_type store_ff [DEPTH];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;

   assign full     = (count_ff == 3'(DEPTH));
   assign empty    = (count_ff == 3'd0);
   assign pop_data = store_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + 2'(push);
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      count_in  = count_ff + 3'(push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) empty |-> !pop)
      else $error("queue read while empty");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 3'd1))
      else $error("queue count lost a beat");
endmodule
`default_nettype wire

// File: hdl/pcp_front.sv
`default_nettype none
module pcp_front
   import pcp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   pcp_req_if.sink             req_if,
   pcp_csr_if.sink             csr_if,
   input  wire pcp_status_type status,
   input  wire logic           q_full,
   output logic                q_push,
   output pcp_cmd_type         q_data
);
   logic [15:0] start_pc_ff, start_pc_in;
   logic        track_ff, track_in;
   logic [15:0] limit_ff, limit_in;
   logic [15:0] last_pc_ff, last_pc_in;
   logic [15:0] loop_first_ff, loop_first_in;
   logic [15:0] loop_last_ff, loop_last_in;
   logic [31:0] loop_times_ff, loop_times_in;
   logic        accept, csr_wr;
   logic [15:0] len;
   logic        qualifies;

   assign req_if.ready = status.clear_done && !q_full;
   assign csr_if.ready = 1'b1;
   assign accept       = req_if.valid && req_if.ready;
   assign csr_wr       = csr_if.valid;

   // pending loop check
   assign len       = loop_last_ff - loop_first_ff;
   assign qualifies = (loop_times_ff > 32'd1) && ((limit_ff == 16'd0) || (len < limit_ff));

   // classify request, track loops
   always_comb begin
      start_pc_in   = start_pc_ff;
      track_in      = track_ff;
      limit_in      = limit_ff;
      last_pc_in    = last_pc_ff;
      loop_first_in = loop_first_ff;
      loop_last_in  = loop_last_ff;
      loop_times_in = loop_times_ff;
      q_push        = 1'b0;
      q_data        = '0;
      q_data.loop_first = loop_first_ff;
      q_data.loop_len   = len;
      q_data.loop_iters = loop_times_ff;
      if (accept) begin
         case (req_if.op)
            OP_RETIRE: begin
               q_push       = 1'b1;
               q_data.upd   = 1'b1;
               q_data.addr  = last_pc_ff;
               q_data.cyc   = req_if.instr_cycles;
               last_pc_in   = req_if.pc;
               if (track_ff) begin
                  if (req_if.pc < last_pc_ff) begin
                     if (req_if.pc == loop_first_ff && last_pc_ff == loop_last_ff) begin
                        loop_times_in = loop_times_ff + 32'd1;
                     end else begin
                        loop_first_in = req_if.pc;
                        loop_last_in  = last_pc_ff;
                        loop_times_in = 32'd1;
                     end
                  end else if (req_if.pc > loop_last_ff) begin
                     q_data.emit   = qualifies;
                     loop_last_in  = PC_NONE;
                     loop_times_in = 32'd0;
                  end
               end
            end
            OP_READ: begin
               q_push      = 1'b1;
               q_data.rd   = 1'b1;
               q_data.addr = req_if.pc;
            end
            OP_FLUSH: begin
               q_push        = qualifies;
               q_data.emit   = qualifies;
               loop_last_in  = PC_NONE;
               loop_times_in = 32'd0;
            end
            default: begin
            end
         endcase
      end
      if (csr_wr) begin
         case (csr_if.index)
            CSR_START_PC: begin
               start_pc_in = csr_if.data;
               last_pc_in  = csr_if.data;
            end
            CSR_LOOP_TRACK: track_in = csr_if.data[0];
            CSR_LOOP_LIMIT: limit_in = csr_if.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pc_ff   <= '0;
         track_ff      <= 1'b0;
         limit_ff      <= '0;
         last_pc_ff    <= '0;
         loop_first_ff <= PC_NONE;
         loop_last_ff  <= PC_NONE;
         loop_times_ff <= '0;
      end else begin
         start_pc_ff   <= start_pc_in;
         track_ff      <= track_in;
         limit_ff      <= limit_in;
         last_pc_ff    <= last_pc_in;
         loop_first_ff <= loop_first_in;
         loop_last_ff  <= loop_last_in;
         loop_times_ff <= loop_times_in;
      end
   end

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      !status.clear_done |-> !accept)
      else $error("request taken during table clear");
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.op == OP_FLUSH) |=> (loop_times_ff == 32'd0))
      else $error("flush left a pending loop");
   a_emit_qualified: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_data.emit) |-> (loop_times_ff > 32'd1))
      else $error("loop record without repeat");
endmodule
`default_nettype wire

// File: hdl/pcp_back.sv
`default_nettype none
module pcp_back
   import pcp_pkg::*;
#(
   parameter int ADDR_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire pcp_cmd_type q_data,
   input  wire logic        q_empty,
   output logic             q_pop,
   output pcp_status_type   status,
   pcp_rsp_if.source        rsp_if
);
   localparam int DEPTH = 1 << ADDR_BITS;

   typedef enum logic [1:0] {CLEAR, IDLE, UPDATE, READ} state_type;

   state_type             state_ff;
   logic [ADDR_BITS-1:0]  clr_ff;
   pcp_cmd_type           cmd_ff;
   pcp_entry_type         rd_ff;
   logic [63:0]           tot_count_ff;
   logic [63:0]           tot_cycles_ff;
   logic                  rsp_valid_ff;
   pcp_rsp_type           rsp_ff;

   pcp_entry_type         mem [DEPTH];
   logic                  mem_we, mem_re;
   logic [ADDR_BITS-1:0]  mem_wa, mem_ra;
   pcp_entry_type         mem_wd, upd_entry, clr_entry;
   logic                  out_free;
   logic                  rsp_load;
   logic [64:0]           cyc_sum;
   pcp_rsp_type           loop_rsp, read_rsp;

   assign out_free          = !rsp_valid_ff || rsp_if.ready;
   assign status.clear_done = (state_ff != CLEAR);

   // entry update from registered read data
   always_comb begin
      upd_entry = rd_ff;
      cyc_sum   = {1'b0, rd_ff.cycles} + {49'd0, cmd_ff.cyc};
      if (rd_ff.count != SAT64) begin
         upd_entry.count = rd_ff.count + 64'd1;
      end
      upd_entry.cycles = cyc_sum[64] ? SAT64 : cyc_sum[63:0];
      if (cmd_ff.cyc < rd_ff.min_cyc) begin
         upd_entry.min_cyc = cmd_ff.cyc;
      end
      if (cmd_ff.cyc > rd_ff.max_cyc) begin
         upd_entry.max_cyc = cmd_ff.cyc;
      end
      clr_entry = '{count: '0, cycles: '0, min_cyc: PC_NONE, max_cyc: '0};
   end

   // result beats
   always_comb begin
      loop_rsp            = '0;
      loop_rsp.kind       = KIND_LOOP;
      loop_rsp.addr       = q_data.loop_first;
      loop_rsp.loop_len   = q_data.loop_len;
      loop_rsp.loop_iters = q_data.loop_iters;
      if (state_ff == UPDATE) begin
         loop_rsp.addr       = cmd_ff.loop_first;
         loop_rsp.loop_len   = cmd_ff.loop_len;
         loop_rsp.loop_iters = cmd_ff.loop_iters;
      end
      read_rsp              = '0;
      read_rsp.kind         = KIND_READ;
      read_rsp.addr         = cmd_ff.addr;
      read_rsp.exec_count   = rd_ff.count;
      read_rsp.cycle_sum    = rd_ff.cycles;
      read_rsp.cycle_spread = (rd_ff.max_cyc != 16'd0) ? (rd_ff.max_cyc - rd_ff.min_cyc) : 16'd0;
      read_rsp.total_count  = tot_count_ff;
      read_rsp.total_cycles = tot_cycles_ff;
   end

   // memory port control
   always_comb begin
      q_pop    = 1'b0;
      rsp_load = 1'b0;
      mem_re   = 1'b0;
      mem_ra   = q_data.addr[ADDR_BITS-1:0];
      mem_we   = 1'b0;
      mem_wa   = cmd_ff.addr[ADDR_BITS-1:0];
      mem_wd   = upd_entry;
      case (state_ff)
         CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = clr_entry;
         end
         IDLE: begin
            if (!q_empty) begin
               if (q_data.rd || q_data.upd) begin
                  q_pop  = 1'b1;
                  mem_re = 1'b1;
               end else if (out_free) begin
                  q_pop    = 1'b1;
                  rsp_load = 1'b1;
               end
            end
         end
         UPDATE: begin
            mem_we   = !cmd_ff.emit || out_free;
            rsp_load = mem_we && cmd_ff.emit;
         end
         READ: rsp_load = out_free;
         default: begin
         end
      endcase
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CLEAR;
         clr_ff        <= '0;
         tot_count_ff  <= '0;
         tot_cycles_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_if.ready);
         case (state_ff)
            CLEAR: begin
               clr_ff <= clr_ff + ADDR_BITS'(1);
               if (clr_ff == {ADDR_BITS{1'b1}}) begin
                  state_ff <= IDLE;
               end
            end
            IDLE: begin
               if (q_pop) begin
                  cmd_ff <= q_data;
                  if (q_data.rd) begin
                     state_ff <= READ;
                  end else if (q_data.upd) begin
                     state_ff <= UPDATE;
                  end else begin
                     rsp_ff <= loop_rsp;
                  end
               end
            end
            UPDATE: begin
               if (mem_we) begin
                  tot_count_ff  <= tot_count_ff + 64'd1;
                  tot_cycles_ff <= tot_cycles_ff + {48'd0, cmd_ff.cyc};
                  state_ff      <= IDLE;
                  if (cmd_ff.emit) begin
                     rsp_ff <= loop_rsp;
                  end
               end
            end
            READ: begin
               if (out_free) begin
                  rsp_ff   <= read_rsp;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.kind         = rsp_ff.kind;
   assign rsp_if.addr         = rsp_ff.addr;
   assign rsp_if.loop_len     = rsp_ff.loop_len;
   assign rsp_if.loop_iters   = rsp_ff.loop_iters;
   assign rsp_if.exec_count   = rsp_ff.exec_count;
   assign rsp_if.cycle_sum    = rsp_ff.cycle_sum;
   assign rsp_if.cycle_spread = rsp_ff.cycle_spread;
   assign rsp_if.total_count  = rsp_ff.total_count;
   assign rsp_if.total_cycles = rsp_ff.total_cycles;

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CLEAR) |-> !q_pop)
      else $error("queue popped during table clear");
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CLEAR) |-> !rsp_valid_ff)
      else $error("result beat during table clear");
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == UPDATE && mem_we) |=> (tot_count_ff == $past(tot_count_ff) + 64'd1))
      else $error("retire total not advanced");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> ($stable(rsp_ff) && rsp_valid_ff))
      else $error("held result beat overwritten");
endmodule
`default_nettype wire

// File: hdl/pc_execution_profiler.sv
`default_nettype none
// Per-address execution profiler.
// req_if carries retire (new pc plus cycles of the instruction at the previous pc),
// entry read and flush beats; rsp_if returns loop records and entry read data;
// csr_if writes start_pc (also loads the previous pc), loop_tracking and loop_len_limit.
// A front stage takes each request, tracks loops and queues a command;
// a back stage works on one command at a time against the entry memory.
// A retire reads its entry in the IDLE state and writes it back in UPDATE, a
// read-modify-write on the entry memory; a read goes through IDLE and READ.
// With the back stage idle, a flush record passes the command queue and the result
// register; a read or a loop record from a retire also passes READ or UPDATE.
// A four-deep command queue lets requests keep coming while a result waits.
// After reset the entry memory is cleared one entry a cycle, all 2**ADDR_BITS entries,
// with req_if.ready low; csr_if is taken at any time.
// When the receiver stalls, the result register holds its beat, the back stage
// waits before producing the next one, and req_if.ready drops once the queue fills.
module pc_execution_profiler
   import pcp_pkg::*;
#(
   parameter int ADDR_BITS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   pcp_req_if.sink   req_if,
   pcp_rsp_if.source rsp_if,
   pcp_csr_if.sink   csr_if
);
   pcp_status_type status;
   pcp_cmd_type    push_data, pop_data;
   logic           q_push, q_pop, q_full, q_empty;

   pcp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .csr_if (csr_if),
      .status (status),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (push_data)
   );

   pcp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   pcp_back #(.ADDR_BITS(ADDR_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_data  (pop_data),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .status  (status),
      .rsp_if  (rsp_if)
   );
endmodule
`default_nettype wire
